### rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the noise filter statistics RTL
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define NFS_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define NFS_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### rtl/core/nfs_pkg.sv
// ---------------------------------------------------------------------------
// nfs_pkg
// Types and constants of the component noise filter statistics unit.
// ---------------------------------------------------------------------------
package nfs_pkg;

   localparam int LABEL_W   = 10;
   localparam int FIELD_W   = 14;
   localparam int COUNT_W   = 28;
   localparam int THR_W     = 16;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 28;

   localparam logic [COUNT_W-1:0] COUNT_MAX       = 28'hFFF_FFFF;
   localparam logic [THR_W-1:0]   WIDTH_THR_RESET = 16'd384;

   localparam logic [CSR_IDX_W-1:0] REG_SIZE_THR  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_WIDTH_THR = 1'b1;

   localparam logic CMD_ACCUM = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ACC,
      ST_PREP,
      ST_MUL1,
      ST_MUL2,
      ST_RESULT
   } nfs_state_type;

   typedef struct packed {
      logic load_op;
      logic clear_step;
      logic acc_write;
      logic prep;
      logic mul1;
      logic mul2;
      logic load_out;
   } nfs_cmd_type;

   typedef struct packed {
      logic sweep_last;
      logic step_last;
      logic rsp_free;
   } nfs_status_type;

endpackage

### rtl/core/nfs_if.sv
// ---------------------------------------------------------------------------
// nfs_req_if / nfs_rsp_if
// Valid/ready channels carrying request and result beats.
// ---------------------------------------------------------------------------
interface nfs_req_if import nfs_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               command;
   logic [LABEL_W-1:0] label;
   logic [FIELD_W-1:0] x;
   logic [FIELD_W-1:0] y;

   modport source (output valid, command, label, x, y, input ready);
   modport sink   (input valid, command, label, x, y, output ready);
endinterface

interface nfs_rsp_if import nfs_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               delete_flag;
   logic [COUNT_W-1:0] pixel_count;
   logic [FIELD_W-1:0] box_top;
   logic [FIELD_W-1:0] box_left;
   logic [FIELD_W-1:0] box_bottom;
   logic [FIELD_W-1:0] box_right;

   modport source (output valid, delete_flag, pixel_count, box_top, box_left,
                   box_bottom, box_right, input ready);
   modport sink   (input valid, delete_flag, pixel_count, box_top, box_left,
                   box_bottom, box_right, output ready);
endinterface

### rtl/core/nfs_ctrl.sv
// ---------------------------------------------------------------------------
// nfs_ctrl
// Sequencer: clearing sweep, accumulate read-modify-write, query multiply.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module nfs_ctrl import nfs_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   input  logic           req_query,
   output logic           req_ready,
   input  nfs_status_type status,
   output nfs_cmd_type    cmd
);

   nfs_state_type state_ff;
   nfs_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (status.sweep_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = req_query ? ST_PREP : ST_ACC;
         end
         ST_ACC: begin
            state_in = ST_IDLE;
         end
         ST_PREP: begin
            state_in = ST_MUL1;
         end
         ST_MUL1: begin
            if (status.step_last) state_in = ST_MUL2;
         end
         ST_MUL2: begin
            if (status.step_last) state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (status.rsp_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
         end
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.load_op = req_valid;
         end
         ST_ACC: begin
            cmd.acc_write = 1'b1;
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
         end
         ST_MUL1: begin
            cmd.mul1 = 1'b1;
         end
         ST_MUL2: begin
            cmd.mul2 = 1'b1;
         end
         ST_RESULT: begin
            cmd.load_out = status.rsp_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   `NFS_ASSERT_NXT(a_pass1_to_pass2, clock, reset, (state_ff == ST_MUL1) && status.step_last, state_ff == ST_MUL2)
   `NFS_ASSERT_NXT(a_accum_goes_rmw, clock, reset, (state_ff == ST_IDLE) && req_valid && !req_query, state_ff == ST_ACC)

endmodule

### rtl/core/nfs_dp.sv
// ---------------------------------------------------------------------------
// nfs_dp
// Label store, box update, serial shift-add noise test and result register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module nfs_dp import nfs_pkg::*; #(
   parameter int MAX_LABELS = 1024,
   parameter int COORD_BITS = 14
) (
   input  logic                  clock,
   input  logic                  reset,
   input  nfs_cmd_type           cmd,
   output nfs_status_type        status,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_command,
   input  logic [LABEL_W-1:0]    req_label,
   input  logic [FIELD_W-1:0]    req_x,
   input  logic [FIELD_W-1:0]    req_y,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_delete_flag,
   output logic [COUNT_W-1:0]    rsp_pixel_count,
   output logic [FIELD_W-1:0]    rsp_box_top,
   output logic [FIELD_W-1:0]    rsp_box_left,
   output logic [FIELD_W-1:0]    rsp_box_bottom,
   output logic [FIELD_W-1:0]    rsp_box_right
);

   localparam int CB    = COORD_BITS;
   localparam int LW    = (MAX_LABELS > 1) ? $clog2(MAX_LABELS) : 1;
   localparam int DW    = CB + 1;
   localparam int SW    = $clog2(DW);
   localparam int ENT_W = COUNT_W + 4 * CB;
   localparam int L_W   = COUNT_W + DW;
   localparam int R1_W  = THR_W + DW;
   localparam int R_W   = THR_W + 2 * DW;
   localparam int CMP_W = (L_W + 8 > R_W) ? L_W + 8 : R_W;

   // configuration
   logic [COUNT_W-1:0] size_thr_ff;
   logic [THR_W-1:0]   width_thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_thr_ff  <= '0;
         width_thr_ff <= WIDTH_THR_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            REG_SIZE_THR:  size_thr_ff  <= COUNT_W'(csr_wdata);
            REG_WIDTH_THR: width_thr_ff <= THR_W'(csr_wdata);
            default: begin
            end
         endcase
      end
   end

   // operation latch
   logic          op_query_ff;
   logic          in_range_ff;
   logic [LW-1:0] addr_ff;
   logic [CB-1:0] x_ff;
   logic [CB-1:0] y_ff;
   logic [LW-1:0] req_addr;

   assign req_addr = LW'(req_label);

   always_ff @(posedge clock) begin
      if (cmd.load_op) begin
         op_query_ff <= (req_command == CMD_QUERY);
         in_range_ff <= (int'(req_label) < MAX_LABELS);
         addr_ff     <= req_addr;
         x_ff        <= CB'(req_x);
         y_ff        <= CB'(req_y);
      end
   end

   // label store: {count, top, left, bottom, right}
   logic [ENT_W-1:0] mem [MAX_LABELS];
   logic [ENT_W-1:0] rd_ff;
   logic [LW-1:0]    clr_addr_ff;
   logic             mem_we;
   logic [LW-1:0]    mem_waddr;
   logic [ENT_W-1:0] mem_wdata;
   logic [ENT_W-1:0] acc_entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else if (cmd.clear_step) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
      end
   end

   always_comb begin
      mem_we = cmd.clear_step || (cmd.acc_write && in_range_ff) ||
               (cmd.prep && op_query_ff && in_range_ff);
      mem_waddr = cmd.clear_step ? clr_addr_ff : addr_ff;
      mem_wdata = cmd.acc_write ? acc_entry : '0;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_op) begin
         rd_ff <= mem[req_addr];
      end
   end

   logic [COUNT_W-1:0] rd_count;
   logic [CB-1:0]      rd_top;
   logic [CB-1:0]      rd_left;
   logic [CB-1:0]      rd_bottom;
   logic [CB-1:0]      rd_right;

   assign rd_count  = rd_ff[ENT_W-1 -: COUNT_W];
   assign rd_top    = rd_ff[4*CB-1 -: CB];
   assign rd_left   = rd_ff[3*CB-1 -: CB];
   assign rd_bottom = rd_ff[2*CB-1 -: CB];
   assign rd_right  = rd_ff[CB-1:0];

   // accumulate: first pixel seeds the box, count saturates
   always_comb begin
      logic [COUNT_W-1:0] cnt_new;
      logic [CB-1:0]      top_new;
      logic [CB-1:0]      left_new;
      logic [CB-1:0]      bot_new;
      logic [CB-1:0]      right_new;
      cnt_new = (rd_count == COUNT_MAX) ? rd_count : rd_count + 1'b1;
      if (rd_count == '0) begin
         top_new   = y_ff;
         bot_new   = y_ff;
         left_new  = x_ff;
         right_new = x_ff;
      end else begin
         top_new   = (y_ff < rd_top)    ? y_ff : rd_top;
         bot_new   = (y_ff > rd_bottom) ? y_ff : rd_bottom;
         left_new  = (x_ff < rd_left)   ? x_ff : rd_left;
         right_new = (x_ff > rd_right)  ? x_ff : rd_right;
      end
      acc_entry = {cnt_new, top_new, left_new, bot_new, right_new};
   end

   // query: box extents
   logic [DW-1:0] h_val;
   logic [DW-1:0] w_val;
   logic [DW-1:0] m_val;

   assign h_val = DW'(rd_bottom) - DW'(rd_top) + 1'b1;
   assign w_val = DW'(rd_right) - DW'(rd_left) + 1'b1;
   assign m_val = (h_val < w_val) ? h_val : w_val;

   // serial shift-add multipliers
   logic [SW-1:0]   step_ff;
   logic [DW-1:0]   mr_m_ff;
   logic [DW-1:0]   mr_h_ff;
   logic [DW-1:0]   mr_w_ff;
   logic [L_W-1:0]  mc_l_ff;
   logic [L_W-1:0]  acc_l_ff;
   logic [R1_W-1:0] mc_r1_ff;
   logic [R1_W-1:0] acc_r1_ff;
   logic [R1_W-1:0] acc_r1_in;
   logic [R_W-1:0]  mc_r_ff;
   logic [R_W-1:0]  acc_r_ff;
   logic            step_last;

   assign step_last = (step_ff == SW'(DW - 1));
   assign acc_r1_in = acc_r1_ff + (mr_h_ff[0] ? mc_r1_ff : '0);

   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         step_ff   <= '0;
         mr_m_ff   <= m_val;
         mr_h_ff   <= h_val;
         mr_w_ff   <= w_val;
         mc_l_ff   <= L_W'(rd_count);
         mc_r1_ff  <= R1_W'(width_thr_ff);
         acc_l_ff  <= '0;
         acc_r1_ff <= '0;
      end else if (cmd.mul1) begin
         step_ff   <= step_last ? '0 : step_ff + 1'b1;
         acc_l_ff  <= acc_l_ff + (mr_m_ff[0] ? mc_l_ff : '0);
         acc_r1_ff <= acc_r1_in;
         mc_l_ff   <= mc_l_ff << 1;
         mc_r1_ff  <= mc_r1_ff << 1;
         mr_m_ff   <= mr_m_ff >> 1;
         mr_h_ff   <= mr_h_ff >> 1;
         if (step_last) begin
            mc_r_ff  <= R_W'(acc_r1_in);
            acc_r_ff <= '0;
         end
      end else if (cmd.mul2) begin
         step_ff  <= step_last ? '0 : step_ff + 1'b1;
         acc_r_ff <= acc_r_ff + (mr_w_ff[0] ? mc_r_ff : '0);
         mc_r_ff  <= mc_r_ff << 1;
         mr_w_ff  <= mr_w_ff >> 1;
      end
   end

   // decision and result register
   logic             empty;
   logic             noise;
   logic [CMP_W-1:0] lhs_cmp;
   logic [CMP_W-1:0] rhs_cmp;
   logic             rsp_valid_ff;
   logic             rsp_delete_ff;
   logic [COUNT_W-1:0] rsp_count_ff;
   logic [FIELD_W-1:0] rsp_top_ff;
   logic [FIELD_W-1:0] rsp_left_ff;
   logic [FIELD_W-1:0] rsp_bottom_ff;
   logic [FIELD_W-1:0] rsp_right_ff;

   assign lhs_cmp = CMP_W'({acc_l_ff, 8'b0});
   assign rhs_cmp = CMP_W'(acc_r_ff);
   assign empty   = !in_range_ff || (rd_count == '0);
   assign noise   = empty || (rd_count <= size_thr_ff) || (lhs_cmp <= rhs_cmp);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_delete_ff <= noise;
         rsp_count_ff  <= empty ? '0 : rd_count;
         rsp_top_ff    <= empty ? '0 : FIELD_W'(rd_top);
         rsp_left_ff   <= empty ? '0 : FIELD_W'(rd_left);
         rsp_bottom_ff <= empty ? '0 : FIELD_W'(rd_bottom);
         rsp_right_ff  <= empty ? '0 : FIELD_W'(rd_right);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_delete_flag = rsp_delete_ff;
   assign rsp_pixel_count = rsp_count_ff;
   assign rsp_box_top     = rsp_top_ff;
   assign rsp_box_left    = rsp_left_ff;
   assign rsp_box_bottom  = rsp_bottom_ff;
   assign rsp_box_right   = rsp_right_ff;

   assign status.sweep_last = (clr_addr_ff == LW'(MAX_LABELS - 1));
   assign status.step_last  = step_last;
   assign status.rsp_free   = !rsp_valid_ff || rsp_ready;

   `NFS_ASSERT_IMP(a_no_result_overwrite, clock, reset, cmd.load_out, !rsp_valid_ff || rsp_ready)
   `NFS_ASSERT_IMP(a_empty_is_deleted, clock, reset, rsp_valid_ff && (rsp_count_ff == '0), rsp_delete_ff)

endmodule

### rtl/core/component_noise_filter_stats_unit.sv
// Accumulate beat: store read, then box update and write back.
// Query beat: store read, operand prep, then the two bit-serial shift-add passes
//   of the width test, then the result register.
// Results wait in an output register; a new beat is taken while one waits.
// Reset (synchronous, active high) starts a clearing pass over the label store;
//   no request beat is taken until it ends.
// ---------------------------------------------------------------------------
// component_noise_filter_stats_unit
// Per-label pixel count and bounding box with a query that returns the
// statistics, a noise delete decision, and clears the label.
// ---------------------------------------------------------------------------
module component_noise_filter_stats_unit import nfs_pkg::*; #(
   parameter int MAX_LABELS = 1024,
   parameter int COORD_BITS = 14
) (
   input  logic                  clock,
   input  logic                  reset,
   nfs_req_if.sink               req,
   nfs_rsp_if.source             rsp,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // Command and status between the sequencer and the datapath.
   nfs_cmd_type    cmd;
   nfs_status_type status;
   logic           req_query;

   // Decode the live command so the sequencer can branch on the accept edge.
   assign req_query = (req.command == CMD_QUERY);

   // Sequencer: owns the handshake on the request side and steps the
   // clearing sweep, the read-modify-write and the multiply passes.
   nfs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_query (req_query),
      .req_ready (req.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: label store, box update, noise test, result register.
   nfs_dp #(
      .MAX_LABELS (MAX_LABELS),
      .COORD_BITS (COORD_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_command     (req.command),
      .req_label       (req.label),
      .req_x           (req.x),
      .req_y           (req.y),
      .rsp_valid       (rsp.valid),
      .rsp_ready       (rsp.ready),
      .rsp_delete_flag (rsp.delete_flag),
      .rsp_pixel_count (rsp.pixel_count),
      .rsp_box_top     (rsp.box_top),
      .rsp_box_left    (rsp.box_left),
      .rsp_box_bottom  (rsp.box_bottom),
      .rsp_box_right   (rsp.box_right)
   );

endmodule
